// ----- rtl/core/dem_tile_nodata_repair_border_macros.svh -----
// Assertion macros for the tile store RTL, included by the datapath.
`ifndef DEM_TILE_NODATA_REPAIR_BORDER_MACROS_SVH
`define DEM_TILE_NODATA_REPAIR_BORDER_MACROS_SVH
`ifndef SYNTHESIS
`define DTNRB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("dtnrb check failed");
`define DTNRB_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("dtnrb bad condition");
`else
`define DTNRB_ASSERT(lbl, clk, rst, prop)
`define DTNRB_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- rtl/core/dtnrb_pkg.sv -----
package dtnrb_pkg;

  localparam int MAX_TILE = 256;
  localparam int STRIDE   = MAX_TILE + 2;
  localparam int DEPTH    = STRIDE * STRIDE;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = 10;
  localparam int DW       = $clog2(MAX_TILE + 1);
  localparam int EW       = 22;
  localparam int FW       = 16;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic [CFG_IW-1:0] CFG_ENCODING  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TILE_SIZE = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_FLOOR     = 2'd2;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FINAL = 2'd1,
    REQ_READ  = 2'd2,
    REQ_WRITE = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FINAL = 2'd1;
  localparam logic [1:0] ST_BAD_COORD = 2'd2;

  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_SCAN,
    TAG_REPAIR,
    TAG_COPY,
    TAG_STATS,
    TAG_READ
  } tag_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_EXEC,
    OP_WALK
  } op_t;

  typedef struct packed {
    op_t                   op;
    tag_t                  tag;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic signed [CW-1:0]  bx;
    logic signed [CW-1:0]  by;
    logic                  capture;
    logic                  commit;
    logic                  fin_done;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    req_t          req;
    logic          busy;
    logic          found;
    logic          out_free;
    logic [DW-1:0] dim;
  } sts_t;

endpackage

// ----- rtl/core/dtnrb_decode.sv -----
// Elevation decode, one register stage. Divide by 10 is a reciprocal multiply.
module dtnrb_decode import dtnrb_pkg::*; (
  input  logic                 clk,
  input  logic                 enc,
  input  logic [23:0]          rgb,
  output logic signed [EW-1:0] elev
);

  localparam logic [23:0] RECIP10 = 24'd13421773;  // ceil(2^27 / 10)

  logic signed [24:0] t_rgb;
  logic signed [24:0] t_ter;
  logic [24:0]        m_rgb;
  logic [24:0]        m_ter;
  logic               enc_r;
  logic               neg_r;
  logic [47:0]        prod_r;
  logic [15:0]        qter_r;
  logic [20:0]        mag;

  always_comb begin
    t_rgb = $signed({1'b0, rgb}) - 25'sd100000;
    t_ter = $signed({1'b0, rgb}) - 25'sd8388608;
    m_rgb = t_rgb[24] ? 25'(-t_rgb) : 25'(t_rgb);
    m_ter = t_ter[24] ? 25'(-t_ter) : 25'(t_ter);
  end

  always_ff @(posedge clk) begin
    enc_r  <= enc;
    neg_r  <= enc ? t_ter[24] : t_rgb[24];
    prod_r <= {24'd0, m_rgb[23:0]} * {24'd0, RECIP10};
    qter_r <= m_ter[23:8];
  end

  assign mag  = enc_r ? {5'd0, qter_r} : prod_r[47:27];
  assign elev = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// ----- rtl/core/dtnrb_datapath.sv -----
`include "dem_tile_nodata_repair_border_macros.svh"
module dtnrb_datapath import dtnrb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [CFG_DW-1:0]      cfg_data,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [1:0]             req_type,
  input  logic signed [CW-1:0]   col,
  input  logic signed [CW-1:0]   row,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  input  logic [7:0]             alpha,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [7:0]             pixel_red,
  output logic [7:0]             pixel_green,
  output logic [7:0]             pixel_blue,
  output logic [7:0]             pixel_alpha,
  output logic signed [EW-1:0]   elevation,
  output logic signed [EW-1:0]   tile_min,
  output logic signed [EW-1:0]   tile_max,
  output logic                   all_nodata,
  output logic [1:0]             status
);

  function automatic logic [AW-1:0] cell_addr(input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y);
    int xi;
    int yi;
    xi = int'(x) + 1;
    yi = int'(y) + 1;
    return AW'(yi * STRIDE + xi);
  endfunction

  logic [31:0] mem [DEPTH];

  logic                 encoding;
  logic [8:0]           tile_size;
  logic signed [FW-1:0] nodata_floor;

  req_t                 q_req;
  logic signed [CW-1:0] q_col;
  logic signed [CW-1:0] q_row;
  logic [31:0]          q_pix;

  logic [DW-1:0]        dim;
  logic signed [CW-1:0] dim_s;
  logic                 interior;
  logic                 framed;
  logic                 exec;
  logic                 host_we;
  logic                 read_ok;
  logic [1:0]           exec_status;

  logic                 rd_en0;
  logic [AW-1:0]        raddr;
  tag_t                 tag0;

  logic                 v1;
  tag_t                 tag1;
  logic [AW-1:0]        a1;
  logic [AW-1:0]        d1;
  logic [31:0]          rdata1;
  logic                 v2;
  tag_t                 tag2;
  logic [AW-1:0]        a2;
  logic [31:0]          word2;
  logic signed [EW-1:0] e2;
  logic signed [EW-1:0] floor_x;
  logic                 below;

  logic                 copy_we;
  logic                 repair_we;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [31:0]          wdata;
  logic [31:0]          rep_word;
  logic [23:0]          q_enc;
  logic [23:0]          s_rgb;

  logic                 found;
  logic signed [EW-1:0] mn;
  logic signed [EW-1:0] min_valid;
  logic signed [EW-1:0] elev_min;
  logic signed [EW-1:0] elev_max;
  logic                 nodata_flag;
  logic                 finalized;
  logic                 stats_first;
  logic [31:0]          res_word;
  logic signed [EW-1:0] res_elev;
  logic [1:0]           res_status;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding     <= 1'b0;
      tile_size    <= 9'd256;
      nodata_floor <= -16'sd600;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENCODING:  encoding     <= cfg_data[0];
        CFG_TILE_SIZE: tile_size    <= cfg_data[8:0];
        CFG_FLOOR:     nodata_floor <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tile_size == 9'd0) begin
      dim = DW'(1);
    end else if (int'(tile_size) > MAX_TILE) begin
      dim = DW'(MAX_TILE);
    end else begin
      dim = DW'(tile_size);
    end
  end

  assign dim_s    = $signed(CW'(dim));
  assign interior = q_col >= 0 && q_col < dim_s && q_row >= 0 && q_row < dim_s;
  assign framed   = q_col >= -1 && q_col <= dim_s && q_row >= -1 && q_row <= dim_s;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_req <= req_t'(req_type);
      q_col <= col;
      q_row <= row;
      q_pix <= {alpha, blue, green, red};
    end
  end

  assign exec    = cmd.op == OP_EXEC;
  assign host_we = exec && ((q_req == REQ_LOAD && interior) ||
                            (q_req == REQ_WRITE && framed && !interior));
  assign read_ok = exec && q_req == REQ_READ && finalized && framed;

  always_comb begin
    unique case (q_req)
      REQ_LOAD:  exec_status = interior ? ST_OK : ST_BAD_COORD;
      REQ_FINAL: exec_status = ST_OK;
      REQ_READ:  exec_status = !finalized ? ST_NOT_FINAL : (framed ? ST_OK : ST_BAD_COORD);
      REQ_WRITE: exec_status = (framed && !interior) ? ST_OK : ST_BAD_COORD;
      default:   exec_status = ST_OK;
    endcase
  end

  assign rd_en0 = read_ok || cmd.op == OP_WALK;
  assign raddr  = read_ok ? cell_addr(q_col, q_row) : cell_addr(cmd.ax, cmd.ay);
  assign tag0   = read_ok ? TAG_READ : cmd.tag;

  // read pipeline: s1 holds memory data, s2 holds decoded elevation
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= rd_en0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    tag1   <= tag0;
    a1     <= raddr;
    d1     <= cell_addr(cmd.bx, cmd.by);
    rdata1 <= mem[raddr];
    tag2   <= tag1;
    a2     <= a1;
    word2  <= rdata1;
  end

  dtnrb_decode u_decode (
    .clk  (clk),
    .enc  (encoding),
    .rgb  ({rdata1[7:0], rdata1[15:8], rdata1[23:16]}),
    .elev (e2)
  );

  assign floor_x = EW'(nodata_floor);
  assign below   = e2 < floor_x;

  // re-encode of the minimum valid elevation
  always_comb begin
    s_rgb = 24'(min_valid + 22'sd10000);
    if (encoding) begin
      q_enc = {16'(min_valid + 22'sd32768), 8'd0};
    end else begin
      q_enc = (s_rgb << 3) + (s_rgb << 1);
    end
    rep_word = {word2[31:24], q_enc[7:0], q_enc[15:8], q_enc[23:16]};
  end

  assign copy_we   = v1 && tag1 == TAG_COPY;
  assign repair_we = v2 && tag2 == TAG_REPAIR && below;

  always_comb begin
    we    = 1'b1;
    waddr = a2;
    wdata = rep_word;
    priority if (host_we) begin
      waddr = cell_addr(q_col, q_row);
      wdata = q_pix;
    end else if (copy_we) begin
      waddr = d1;
      wdata = rdata1;
    end else if (repair_we) begin
      waddr = a2;
      wdata = rep_word;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // tile state
  always_ff @(posedge clk) begin
    if (rst) begin
      found       <= 1'b0;
      mn          <= '0;
      min_valid   <= '0;
      elev_min    <= '0;
      elev_max    <= '0;
      nodata_flag <= 1'b0;
      finalized   <= 1'b0;
      stats_first <= 1'b0;
      res_word    <= '0;
      res_elev    <= '0;
      res_status  <= ST_OK;
    end else begin
      if (exec) begin
        found      <= 1'b0;
        res_word   <= '0;
        res_elev   <= '0;
        res_status <= exec_status;
      end
      if (host_we && q_req == REQ_LOAD) begin
        finalized <= 1'b0;
      end
      if (v2 && tag2 == TAG_SCAN && !below && (!found || e2 < mn)) begin
        mn    <= e2;
        found <= 1'b1;
      end
      if (cmd.commit) begin
        nodata_flag <= !found;
        stats_first <= 1'b1;
        if (found) begin
          min_valid <= mn;
        end
      end
      if (v2 && tag2 == TAG_STATS) begin
        if (stats_first) begin
          elev_min    <= e2;
          elev_max    <= e2;
          stats_first <= 1'b0;
        end else begin
          if (e2 < elev_min) elev_min <= e2;
          if (e2 > elev_max) elev_max <= e2;
        end
      end
      if (v2 && tag2 == TAG_READ) begin
        res_word <= word2;
        res_elev <= e2;
      end
      if (cmd.fin_done) begin
        finalized <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_red   <= res_word[7:0];
      pixel_green <= res_word[15:8];
      pixel_blue  <= res_word[23:16];
      pixel_alpha <= res_word[31:24];
      elevation   <= res_elev;
      tile_min    <= elev_min;
      tile_max    <= elev_max;
      all_nodata  <= nodata_flag;
      status      <= res_status;
    end
  end

  always_comb begin
    sts.req      = q_req;
    sts.busy     = v1 || v2;
    sts.found    = found;
    sts.out_free = !out_valid || !out_stall;
    sts.dim      = dim;
  end

  `DTNRB_ASSERT(a_one_writer, clk, rst, $onehot0({host_we, copy_we, repair_we}))
  `DTNRB_ASSERT(a_exec_drained, clk, rst, (cmd.op == OP_EXEC) |-> !(v1 || v2))
  `DTNRB_ASSERT(a_fin_drained, clk, rst, cmd.fin_done |-> !(v1 || v2))
  `DTNRB_NEVER(a_no_overrun, clk, rst, cmd.out_load && out_valid && out_stall)

endmodule

// ----- rtl/core/dtnrb_ctrl.sv -----
module dtnrb_ctrl import dtnrb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SCAN_DR,
    S_REPAIR,
    S_REPAIR_DR,
    S_COLS,
    S_COLS_DR,
    S_ROWS,
    S_ROWS_DR,
    S_STATS,
    S_STATS_DR,
    S_DONE
  } state_t;

  state_t               state;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic                 sub;
  logic signed [CW-1:0] dp;
  logic signed [CW-1:0] dm1;
  logic                 row_end;
  logic                 tile_end;

  assign dp       = $signed(CW'(sts.dim));
  assign dm1      = dp - CW'(1);
  assign row_end  = cx == dm1;
  assign tile_end = row_end && cy == dm1;
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cx    <= '0;
      cy    <= '0;
      sub   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          cx  <= '0;
          cy  <= '0;
          sub <= 1'b0;
          state <= (sts.req == REQ_FINAL) ? S_SCAN : S_DONE;
        end
        S_SCAN, S_REPAIR, S_STATS: begin
          if (row_end) begin
            cx <= '0;
            cy <= cy + CW'(1);
          end else begin
            cx <= cx + CW'(1);
          end
          if (tile_end) begin
            unique case (state)
              S_SCAN:   state <= S_SCAN_DR;
              S_REPAIR: state <= S_REPAIR_DR;
              default:  state <= S_STATS_DR;
            endcase
          end
        end
        S_SCAN_DR: begin
          if (!sts.busy) begin
            cx <= '0;
            cy <= '0;
            state <= sts.found ? S_REPAIR : S_COLS;
          end
        end
        S_REPAIR_DR: begin
          if (!sts.busy) begin
            cy <= '0;
            sub <= 1'b0;
            state <= S_COLS;
          end
        end
        S_COLS: begin
          sub <= !sub;
          if (sub) begin
            cy <= cy + CW'(1);
            if (cy == dm1) state <= S_COLS_DR;
          end
        end
        S_COLS_DR: begin
          if (!sts.busy) begin
            cx  <= -CW'(1);
            sub <= 1'b0;
            state <= S_ROWS;
          end
        end
        S_ROWS: begin
          sub <= !sub;
          if (sub) begin
            cx <= cx + CW'(1);
            if (cx == dp) state <= S_ROWS_DR;
          end
        end
        S_ROWS_DR: begin
          if (!sts.busy) begin
            cx <= '0;
            cy <= '0;
            state <= S_STATS;
          end
        end
        S_STATS_DR: begin
          if (!sts.busy) state <= S_DONE;
        end
        S_DONE: begin
          if (!sts.busy && sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.tag      = TAG_NONE;
    cmd.ax       = cx;
    cmd.ay       = cy;
    cmd.bx       = cx;
    cmd.by       = cy;
    cmd.capture  = state == S_IDLE && in_valid;
    unique case (state)
      S_EXEC: cmd.op = OP_EXEC;
      S_SCAN: begin
        cmd.op  = OP_WALK;
        cmd.tag = TAG_SCAN;
      end
      S_REPAIR: begin
        cmd.op  = OP_WALK;
        cmd.tag = TAG_REPAIR;
      end
      S_STATS: begin
        cmd.op  = OP_WALK;
        cmd.tag = TAG_STATS;
      end
      S_COLS: begin
        cmd.op  = OP_WALK;
        cmd.tag = TAG_COPY;
        cmd.ax  = sub ? dm1 : CW'(0);
        cmd.bx  = sub ? dp : -CW'(1);
      end
      S_ROWS: begin
        // top row takes row 0, bottom row the last interior row, corners included
        cmd.op  = OP_WALK;
        cmd.tag = TAG_COPY;
        cmd.ay  = sub ? dm1 : CW'(0);
        cmd.by  = sub ? dp : -CW'(1);
      end
      S_SCAN_DR: cmd.commit = !sts.busy;
      S_STATS_DR: cmd.fin_done = !sts.busy;
      S_DONE: cmd.out_load = !sts.busy && sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/dem_tile_nodata_repair_border.sv -----
// Elevation tile store with NoData repair and a one-pixel border.
// Input channel (in_valid / in_stall) carries one request word: load an
// interior pixel, finalize, read a pixel, or write a border pixel. Every
// request yields exactly one result word on the output channel
// (out_valid / out_stall) with pixel bytes, decoded elevation, tile range,
// NoData flag and status.
// Requests are handled one at a time. A good read passes through the memory
// read register and the decode multiply stage before its result is loaded.
// Finalize walks the tile in the 258x258 store with one memory access per
// cycle (scan, repair when a valid minimum exists, border copy, range pass).
// A new request is accepted as soon as the previous one has finished, even
// while its result is still held for a stalled receiver; the next result
// then waits until that word is taken.
// Synchronous reset clears control state and restores the register
// defaults; pixel memory is not cleared and reads as unknown until written.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module dem_tile_nodata_repair_border import dtnrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            req_type,
  input  logic signed [CW-1:0]  col,
  input  logic signed [CW-1:0]  row,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [7:0]            alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            pixel_red,
  output logic [7:0]            pixel_green,
  output logic [7:0]            pixel_blue,
  output logic [7:0]            pixel_alpha,
  output logic signed [EW-1:0]  elevation,
  output logic signed [EW-1:0]  tile_min,
  output logic signed [EW-1:0]  tile_max,
  output logic                  all_nodata,
  output logic [1:0]            status
);

  cmd_t cmd;
  sts_t sts;

  dtnrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtnrb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .col         (col),
    .row         (row),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .pixel_alpha (pixel_alpha),
    .elevation   (elevation),
    .tile_min    (tile_min),
    .tile_max    (tile_max),
    .all_nodata  (all_nodata),
    .status      (status)
  );

endmodule
